// ----- src/lru_keyed_cache_assert.svh -----
// Assertion macros shared by the cache RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef LRU_KEYED_CACHE_ASSERT_SVH
`define LRU_KEYED_CACHE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define LKC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru_keyed_cache: assertion failed");

// Condition must hold in the cycle after the trigger
`define LKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru_keyed_cache: assertion failed");

`endif

// ----- src/lkc_pkg.sv -----
`default_nettype none
package lkc_pkg;

    // Default geometry
    localparam int unsigned LKC_ENTRIES     = 16;
    localparam int unsigned LKC_KEY_BITS    = 64;
    localparam int unsigned LKC_HANDLE_BITS = 32;

    // Fixed port widths
    localparam int unsigned LKC_MODE_W   = 2;
    localparam int unsigned LKC_KEY_W    = 64;
    localparam int unsigned LKC_HANDLE_W = 32;
    localparam int unsigned LKC_COUNT_W  = 5;

    // Operation codes; the fourth code is a no-op
    typedef enum logic [LKC_MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // Per-cell update control for one cycle
    typedef struct packed {
        logic load_new;   // take the incoming key/handle
        logic shift;      // take the neighbour's contents
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- src/lkc_cell.sv -----
`default_nettype none
module lkc_cell
    import lkc_pkg::*;
#(
    parameter int unsigned KEY_BITS    = LKC_KEY_BITS,
    parameter int unsigned HANDLE_BITS = LKC_HANDLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // compare side
    input  wire logic                   i_cmp_en,
    input  wire logic                   i_slot_valid,
    input  wire logic [KEY_BITS-1:0]    i_cmp_key,
    output logic                        o_match,
    // update side
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [KEY_BITS-1:0]    i_new_tag,
    input  wire logic [HANDLE_BITS-1:0] i_new_handle,
    input  wire logic [KEY_BITS-1:0]    i_nb_tag,
    input  wire logic [HANDLE_BITS-1:0] i_nb_handle,
    output logic [KEY_BITS-1:0]         o_tag,
    output logic [HANDLE_BITS-1:0]      o_handle
);

    logic [KEY_BITS-1:0]    r_tag;
    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_match;

    // Tag compare, captured with the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= i_slot_valid && (r_tag == i_cmp_key);
        end
    end

    // Slot contents: load new entry, shift from the younger neighbour, or hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_tag    <= i_new_tag;
            r_handle <= i_new_handle;
        end else if (i_ctl.shift) begin
            r_tag    <= i_nb_tag;
            r_handle <= i_nb_handle;
        end
    end

    assign o_match  = r_match;
    assign o_tag    = r_tag;
    assign o_handle = r_handle;

endmodule
`default_nettype wire

// ----- src/lru_keyed_cache.sv -----
// Channel | Direction | Handshake          | Payload
// in      | into      | i_valid / o_stall  | i_mode, i_key, i_handle
// out     | out of    | o_valid / i_stall  | o_hit, o_handle_out, o_entry_count
//
// Each beat takes two steps: the first registers every cell's tag compare, the
// second shifts the row of cells and loads the result register.
// Input stalls until that second step is done; the update waits while a held result is stalled.
// Synchronous active-low reset empties the cache at once (no clearing pass).
// A held result blocks only the update, so one beat can wait ahead of it.
`default_nettype none
module lru_keyed_cache
    import lkc_pkg::*;
#(
    parameter int unsigned ENTRIES     = LKC_ENTRIES,
    parameter int unsigned KEY_BITS    = LKC_KEY_BITS,
    parameter int unsigned HANDLE_BITS = LKC_HANDLE_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [LKC_MODE_W-1:0]   i_mode,
    input  wire logic [LKC_KEY_W-1:0]    i_key,
    input  wire logic [LKC_HANDLE_W-1:0] i_handle,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_hit,
    output logic [LKC_HANDLE_W-1:0]      o_handle_out,
    output logic [LKC_COUNT_W-1:0]       o_entry_count
);

`include "lru_keyed_cache_assert.svh"

    localparam int unsigned FW = $clog2(ENTRIES + 1);

    // Pending beat
    logic                   r_pend;
    logic [LKC_MODE_W-1:0]  r_mode;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [FW-1:0]          r_fill;
    logic [FW-1:0]          n_fill;

    // Result register
    logic                    r_out_valid;
    logic                    r_hit;
    logic [LKC_HANDLE_W-1:0] r_hout;
    logic [LKC_COUNT_W-1:0]  r_count;

    logic accept;
    logic update;

    logic [ENTRIES-1:0]     w_match;
    logic [ENTRIES-1:0]     w_seen;
    logic [ENTRIES-1:0]     w_slot_valid;
    logic [KEY_BITS-1:0]    w_tag    [ENTRIES];
    logic [HANDLE_BITS-1:0] w_hnd    [ENTRIES];
    t_cell_ctl              w_ctl    [ENTRIES];
    logic [HANDLE_BITS-1:0] w_hout;
    logic [HANDLE_BITS-1:0] w_new_handle;
    logic                   w_any;
    logic                   w_remove;
    logic                   w_append;
    logic                   w_evict;
    logic                   w_lookup_hit;
    logic [FW-1:0]          w_pos_new;

    assign o_stall = r_pend;
    assign accept  = i_valid && !r_pend;
    assign update  = r_pend && (!r_out_valid || !i_stall);

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (update) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_key    <= KEY_BITS'(i_key);
            r_handle <= HANDLE_BITS'(i_handle);
        end
    end

    // Row of cells; each shifts from its younger neighbour
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]    nb_tag;
        logic [HANDLE_BITS-1:0] nb_hnd;

        if (g == ENTRIES - 1) begin : g_last
            assign nb_tag = '0;
            assign nb_hnd = '0;
        end else begin : g_mid
            assign nb_tag = w_tag[g+1];
            assign nb_hnd = w_hnd[g+1];
        end

        assign w_slot_valid[g] = FW'(g) < r_fill;

        lkc_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmp_en     (accept),
            .i_slot_valid (w_slot_valid[g]),
            .i_cmp_key    (KEY_BITS'(i_key)),
            .o_match      (w_match[g]),
            .i_ctl        (w_ctl[g]),
            .i_new_tag    (r_key),
            .i_new_handle (w_new_handle),
            .i_nb_tag     (nb_tag),
            .i_nb_handle  (nb_hnd),
            .o_tag        (w_tag[g]),
            .o_handle     (w_hnd[g])
        );

        // cells at or above the hit close the gap
        if (g == 0) begin : g_seen0
            assign w_seen[g] = w_match[g];
        end else begin : g_seenn
            assign w_seen[g] = w_seen[g-1] | w_match[g];
        end
    end

    assign w_any = w_seen[ENTRIES-1];

    // Handle of the matching cell (at most one matches)
    always_comb begin
        w_hout = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hout = w_hout | (w_hnd[i] & {HANDLE_BITS{w_match[i]}});
        end
    end

    // Decode the pending operation
    always_comb begin
        w_remove     = 1'b0;
        w_append     = 1'b0;
        w_evict      = 1'b0;
        w_lookup_hit = 1'b0;
        w_new_handle = r_handle;
        n_fill       = r_fill;
        unique case (r_mode)
            MODE_LOOKUP: begin
                w_lookup_hit = w_any;
                w_remove     = w_any;
                w_append     = w_any;
                w_new_handle = w_hout;
            end
            MODE_INSERT: begin
                w_evict  = !w_any && (r_fill == FW'(ENTRIES));
                w_remove = w_any || w_evict;
                w_append = 1'b1;
            end
            MODE_CLEAR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
        if (r_mode != MODE_CLEAR) begin
            n_fill = r_fill - FW'(w_remove) + FW'(w_append);
        end
        w_pos_new = w_remove ? r_fill - FW'(1) : r_fill;
    end

    // Per-cell control
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctl[i].load_new = update && w_append && (FW'(i) == w_pos_new);
            w_ctl[i].shift    = update && w_remove && (w_seen[i] || w_evict)
                                && !(w_append && (FW'(i) == w_pos_new));
        end
    end

    // Fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (update) begin
            r_fill <= n_fill;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (update) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (update) begin
            r_hit   <= w_lookup_hit;
            r_hout  <= w_lookup_hit ? LKC_HANDLE_W'(w_hout) : '0;
            r_count <= LKC_COUNT_W'(n_fill);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_handle_out  = r_hout;
    assign o_entry_count = r_count;

    // Checks
    `LKC_ASSERT_NOW(a_match_onehot, r_pend, $onehot0(w_match))
    `LKC_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FW'(ENTRIES))
    `LKC_ASSERT_NEXT(a_update_result, update, r_out_valid && !r_pend)
    `LKC_ASSERT_NOW(a_hit_nonempty, r_out_valid && r_hit, r_count != '0)

endmodule
`default_nettype wire
